FILE: hw/rtl/art_pkg.sv
// ----------------------------------------------------------------------------
// art_pkg
// Shared constants, types and helpers of the address region table.
// ----------------------------------------------------------------------------
`default_nettype none
package art_pkg;

  localparam int MAX_REGIONS = 32;
  localparam int PAGE_BYTES  = 4096;
  localparam int PAGE_LOG    = $clog2(PAGE_BYTES);
  localparam int CNT_W       = $clog2(MAX_REGIONS) + 1;
  localparam int WIDE_W      = 35;

  localparam logic [WIDE_W-1:0] PAGE_MASK = ~(WIDE_W'(PAGE_BYTES - 1));
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_REGIONS);
  localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(MAX_REGIONS - 1);

  localparam logic [31:0] DEFAULT_HINT_RST = 32'hD000_0000;
  localparam logic [31:0] SEARCH_LIMIT_RST = 32'hFFFF_F000;
  localparam logic [3:0]  KERNEL_KIND_MAX  = 4'd5;

  localparam logic [2:0] CMD_MAP   = 3'd0;
  localparam logic [2:0] CMD_UNMAP = 3'd1;
  localparam logic [2:0] CMD_FIND  = 3'd2;
  localparam logic [2:0] CMD_FREE  = 3'd3;
  localparam logic [2:0] CMD_FAULT = 3'd4;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_MISALIGNED = 3'd1;
  localparam logic [2:0] ST_OVERLAP    = 3'd2;
  localparam logic [2:0] ST_FULL       = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd4;
  localparam logic [2:0] ST_PROTECTED  = 3'd5;
  localparam logic [2:0] ST_NO_GAP     = 3'd6;

  localparam logic [1:0] FK_OUTSIDE     = 2'd0;
  localparam logic [1:0] FK_NOT_PRESENT = 2'd1;
  localparam logic [1:0] FK_PROTECTION  = 2'd2;

  localparam logic REG_DEFAULT_HINT = 1'b0;
  localparam logic REG_SEARCH_LIMIT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_INSERT,
    S_DELETE,
    S_RESP
  } art_state_t;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] size;
    logic [7:0]  attr;
  } art_entry_t;

  function automatic logic [WIDE_W-1:0] page_up(input logic [WIDE_W-1:0] x);
    return (x + WIDE_W'(PAGE_BYTES - 1)) & PAGE_MASK;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/art_cell.sv
// ----------------------------------------------------------------------------
// art_cell
// One table slot; takes the entry on its d input on every shift (its neighbour's, or the feed for the tail).
// ----------------------------------------------------------------------------
`default_nettype none
module art_cell
  import art_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       shift,
  input  wire art_entry_t d,
  output art_entry_t      q
);

  art_entry_t entry;

  always_ff @(posedge clk) begin
    if (shift) begin
      entry <= d;
    end
  end

  assign q = entry;

endmodule
`default_nettype wire

FILE: hw/rtl/address_region_table.sv
// ----------------------------------------------------------------------------
// address_region_table
// Sorted table of virtual address regions held in a ring of cells.
// ----------------------------------------------------------------------------
// Raise start with a command while busy is low; the transaction is taken at
// that edge and busy stays high until the result has been shown.
// The result appears on the output ports for one cycle with done high.
// The entries sit in a ring of MAX_REGIONS cells that rotates one place per
// cycle while scanning, inserting or deleting; the controller inspects the
// head cell and feeds the tail. A misaligned map or an unknown command goes
// straight to the result. Find, find-free, fault and rejected map/unmap scan
// the ring once, then finish and show the result. A successful map adds an
// insert rotation, a successful unmap a delete rotation, before the result.
// One transaction is in flight at a time; the ring rotation sets the rate.
// Registers on the APB port: default_hint at 0x0, search_limit at 0x4,
// written by the user only while busy is low; the block does not enforce this.
// Reset empties the table and loads the register defaults; no clearing
// pass is needed. The receiver cannot stall results.
// ----------------------------------------------------------------------------
`default_nettype none
module address_region_table
  import art_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  command,
  input  wire logic [31:0] address,
  input  wire logic [31:0] length,
  input  wire logic [3:0]  access_flags,
  input  wire logic [3:0]  region_kind,
  input  wire logic [2:0]  fault_code,
  output logic             done,
  output logic [2:0]       status,
  output logic             hit,
  output logic [31:0]      hit_base,
  output logic [31:0]      hit_size,
  output logic [3:0]       hit_flags,
  output logic [3:0]       hit_kind,
  output logic [31:0]      free_start,
  output logic [1:0]       fault_kind,
  output logic             write_to_read_only,
  output logic             user_to_kernel,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  art_state_t state, state_next;

  art_entry_t ring [MAX_REGIONS];
  art_entry_t feed;
  art_entry_t head;
  art_entry_t held;
  logic       shift;

  logic [31:0] default_hint, search_limit;
  logic [CNT_W-1:0] count, step, pos, idx;
  logic [2:0]  cmd;
  logic [31:0] addr, len;
  logic [3:0]  flags, kind;
  logic [2:0]  err;
  logic        found, stop, first_eq;
  logic [WIDE_W-1:0] cand, want;

  logic              valid;
  logic [WIDE_W-1:0] h_base, h_end, lim, top, nend, a_wide;
  logic              misaligned, accept, step_last;

  assign pready = 1'b1;
  assign accept = start && (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      default_hint <= DEFAULT_HINT_RST;
      search_limit <= SEARCH_LIMIT_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_DEFAULT_HINT) default_hint <= pwdata;
      else if (paddr[2] == REG_SEARCH_LIMIT) search_limit <= pwdata;
    end
  end

  assign prdata = (paddr[2] == REG_DEFAULT_HINT) ? default_hint : search_limit;

  genvar k;
  generate
    for (k = 0; k < MAX_REGIONS; k++) begin : g_cell
      if (k == MAX_REGIONS - 1) begin : g_tail
        art_cell u_cell (.clk(clk), .shift(shift), .d(feed), .q(ring[k]));
      end else begin : g_body
        art_cell u_cell (.clk(clk), .shift(shift), .d(ring[k+1]), .q(ring[k]));
      end
    end
  endgenerate

  assign head   = ring[0];
  assign valid  = step < count;
  assign h_base = WIDE_W'(head.base);
  assign h_end  = WIDE_W'(head.base) + WIDE_W'(head.size);
  assign lim    = WIDE_W'(search_limit);
  assign top    = (h_base < lim) ? h_base : lim;
  assign a_wide = WIDE_W'(addr);
  assign nend   = a_wide + WIDE_W'(len);
  assign misaligned = (address[PAGE_LOG-1:0] != '0) || (length[PAGE_LOG-1:0] != '0);

  always_comb begin
    step_last = 1'b0;
    case (state)
      S_SCAN:   step_last = (step == CNT_LAST);
      S_INSERT: step_last = (step == CNT_LAST);
      S_DELETE: step_last = (step == CNT_MAX);
      default:  step_last = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if ((command == CMD_MAP && misaligned) || command > CMD_FAULT) state_next = S_RESP;
          else state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (step_last) state_next = S_FINISH;
      end
      S_FINISH: begin
        state_next = S_RESP;
        if (cmd == CMD_MAP && !found && count != CNT_MAX) state_next = S_INSERT;
        if (cmd == CMD_UNMAP && found && hit_kind > KERNEL_KIND_MAX) state_next = S_DELETE;
      end
      S_INSERT: begin
        if (step_last) state_next = S_RESP;
      end
      S_DELETE: begin
        if (step_last) state_next = S_RESP;
      end
      S_RESP:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy  = (state != S_IDLE);
    done  = (state == S_RESP);
    shift = 1'b0;
    feed  = head;
    case (state)
      S_SCAN: shift = 1'b1;
      S_INSERT: begin
        shift = 1'b1;
        if (step == pos) feed = '{base: addr, size: len, attr: {kind, flags}};
        else if (step > pos) feed = held;
      end
      S_DELETE: begin
        shift = 1'b1;
        if (step <= idx) feed = held;
      end
      default: shift = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == S_INSERT && step_last) count <= count + 1'b1;
      if (state == S_DELETE && step_last) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    held <= head;
    if (state == S_SCAN || state == S_INSERT || state == S_DELETE) step <= step + 1'b1;
    if (accept) begin
      cmd      <= command;
      addr     <= address;
      len      <= length;
      flags    <= access_flags;
      kind     <= region_kind;
      err      <= fault_code;
      step     <= '0;
      pos      <= '0;
      idx      <= '0;
      found    <= 1'b0;
      stop     <= 1'b0;
      first_eq <= 1'b0;
      want     <= page_up(WIDE_W'(length));
      cand     <= page_up(WIDE_W'((address != '0) ? address : default_hint));
      status   <= (command == CMD_MAP) ? ST_MISALIGNED : ST_NOT_FOUND;
      hit      <= 1'b0;
      hit_base <= '0;
      hit_size <= '0;
      hit_flags <= '0;
      hit_kind  <= '0;
      free_start <= '0;
      fault_kind <= FK_OUTSIDE;
      write_to_read_only <= 1'b0;
      user_to_kernel     <= 1'b0;
    end
    if (state == S_SCAN && valid && !found) begin
      case (cmd)
        CMD_MAP: begin
          if (a_wide < h_end && nend > h_base) begin
            found <= 1'b1;
            hit <= 1'b1; hit_base <= head.base; hit_size <= head.size;
            hit_flags <= head.attr[3:0]; hit_kind <= head.attr[7:4];
          end
        end
        CMD_UNMAP: begin
          if (head.base == addr) begin
            found <= 1'b1; idx <= step;
            hit <= 1'b1; hit_base <= head.base; hit_size <= head.size;
            hit_flags <= head.attr[3:0]; hit_kind <= head.attr[7:4];
          end
        end
        CMD_FIND, CMD_FAULT: begin
          if (addr >= head.base && a_wide < h_end) begin
            found <= 1'b1;
            hit <= 1'b1; hit_base <= head.base; hit_size <= head.size;
            hit_flags <= head.attr[3:0]; hit_kind <= head.attr[7:4];
          end
        end
        CMD_FREE: begin
          if (cand + want <= top) begin
            found <= 1'b1;
            free_start <= cand[31:0];
          end else if (cand < h_end) begin
            cand <= page_up(h_end);
          end
        end
        default: found <= found;
      endcase
    end
    if (state == S_SCAN && cmd == CMD_MAP && valid && !stop) begin
      if (head.base < addr) pos <= pos + 1'b1;
      else stop <= 1'b1;
      if (step == '0) first_eq <= (head.base == addr);
    end
    if (state == S_FINISH) begin
      case (cmd)
        CMD_MAP: begin
          if (found) status <= ST_OVERLAP;
          else if (count == CNT_MAX) status <= ST_FULL;
          else status <= ST_OK;
          if (pos == '0 && count != '0 && first_eq) pos <= CNT_W'(1);
        end
        CMD_UNMAP: begin
          if (!found) status <= ST_NOT_FOUND;
          else if (hit_kind <= KERNEL_KIND_MAX) status <= ST_PROTECTED;
          else status <= ST_OK;
        end
        CMD_FIND: status <= found ? ST_OK : ST_NOT_FOUND;
        CMD_FREE: begin
          if (found) status <= ST_OK;
          else if (cand + want <= lim) begin
            status <= ST_OK;
            free_start <= cand[31:0];
          end else status <= ST_NO_GAP;
        end
        CMD_FAULT: begin
          status <= ST_OK;
          if (found) begin
            if (!err[0]) fault_kind <= FK_NOT_PRESENT;
            else begin
              fault_kind <= FK_PROTECTION;
              write_to_read_only <= err[1] && !hit_flags[1];
              user_to_kernel     <= err[2] && !hit_flags[3];
            end
          end
        end
        default: status <= ST_NOT_FOUND;
      endcase
    end
    if (state == S_FINISH) step <= '0;
  end

endmodule
`default_nettype wire
